[src/vfsgf_pkg.sv]
// shared types and constants of the voice frame sequence gap filler
package vfsgf_pkg;

   localparam int unsigned SEQ_PERIOD = 21;
   localparam int unsigned GAP_CAP    = 19;

   localparam int unsigned SEQ_W      = 5;
   localparam int unsigned CNT_W      = 5;
   localparam int unsigned HANG_W     = 5;
   localparam int unsigned MISSED_W   = 4;
   localparam int unsigned GAP_W      = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 5;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned SEQ_BYTE_W = 8;
   localparam int unsigned VOICE_LO_W = 64;
   localparam int unsigned VOICE_HI_W = 8;
   localparam int unsigned SLOW_W     = 24;
   localparam int unsigned EVENT_W    = 3;
   localparam int unsigned END_BIT    = 6;

   localparam logic [HANG_W-1:0]   HANG_RESET_VAL   = 5'd30;
   localparam logic [MISSED_W-1:0] MISSED_RESET_VAL = 4'd8;
   localparam logic [GAP_W-1:0]    MAX_GAP_RESET    = 5'd18;
   localparam logic [CNT_W-1:0]    HDR_FRAMES       = 5'd3;

   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HANG_PASSES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISSED_PASSES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP       = 2'd2;

   typedef enum logic [EVENT_W-1:0] {
      EV_VOICE = 3'd0,
      EV_SYNC  = 3'd1,
      EV_ADD   = 3'd2,
      EV_RESET = 3'd3,
      EV_IDLE  = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      OP_FILL_SLOW,
      OP_FILL_VOICE,
      OP_FRAME_SLOW,
      OP_FRAME_VOICE,
      OP_SLOW_RESET,
      OP_GO_IDLE
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DISPATCH,
      ST_HDR_VOICE,
      ST_HDR_RESET,
      ST_FILL_SLOW,
      ST_FILL_VOICE,
      ST_FRAME_SLOW,
      ST_FRAME_VOICE,
      ST_HANG_IDLE,
      ST_HANG_RESET
   } state_type;

   typedef struct packed {
      logic   capture;
      logic   decode;
      logic   emit;
      op_type op;
      logic   last;
      logic   cnt_dec;
   } dp_cmd_type;

   typedef struct packed {
      logic emit_ok;
      logic plan_header;
      logic plan_frame;
      logic plan_hang;
      logic cnt_last;
      logic cnt_zero;
   } dp_status_type;

endpackage

[src/voice_frame_sequence_gap_filler.sv]
// top level of the voice frame sequence gap filler
// One request beat is one pass of the receive loop (idle, header or data frame) and
// produces zero to forty response beats, the last one flagged by rsp_last. A pass is
// captured in the idle state, decoded, and planned in the dispatch state; then the
// response beats follow one per cycle while the consumer takes them without stalling.
// The rate is set by the single result register fed by the controller, which emits at
// most one beat per cycle; the next request is taken once the last beat of the pass is
// in the result register.
module voice_frame_sequence_gap_filler import vfsgf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [SEQ_BYTE_W-1:0] req_seq_byte,
   input  logic [VOICE_LO_W-1:0] req_voice_low,
   input  logic [VOICE_HI_W-1:0] req_voice_high,
   input  logic [SLOW_W-1:0]     req_slow_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [EVENT_W-1:0]    rsp_event_res,
   output logic                  rsp_silence,
   output logic [VOICE_LO_W-1:0] rsp_voice_low_res,
   output logic [VOICE_HI_W-1:0] rsp_voice_high_res,
   output logic [SLOW_W-1:0]     rsp_slow_data_res,
   output logic                  rsp_last
);

   dp_cmd_type    cmd;
   dp_status_type status;

   vfsgf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   vfsgf_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_kind           (req_kind),
      .req_seq_byte       (req_seq_byte),
      .req_voice_low      (req_voice_low),
      .req_voice_high     (req_voice_high),
      .req_slow_data      (req_slow_data),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_event_res      (rsp_event_res),
      .rsp_silence        (rsp_silence),
      .rsp_voice_low_res  (rsp_voice_low_res),
      .rsp_voice_high_res (rsp_voice_high_res),
      .rsp_slow_data_res  (rsp_slow_data_res),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

[src/vfsgf_dp.sv]
// datapath: pass state, configuration, captured frame and result register
module vfsgf_dp import vfsgf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [SEQ_BYTE_W-1:0] req_seq_byte,
   input  logic [VOICE_LO_W-1:0] req_voice_low,
   input  logic [VOICE_HI_W-1:0] req_voice_high,
   input  logic [SLOW_W-1:0]     req_slow_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [EVENT_W-1:0]    rsp_event_res,
   output logic                  rsp_silence,
   output logic [VOICE_LO_W-1:0] rsp_voice_low_res,
   output logic [VOICE_HI_W-1:0] rsp_voice_high_res,
   output logic [SLOW_W-1:0]     rsp_slow_data_res,
   output logic                  rsp_last,
   input  dp_cmd_type            cmd,
   output dp_status_type         status
);

   localparam logic [SEQ_W:0] PERIOD = (SEQ_W+1)'(SEQ_PERIOD);
   localparam logic [GAP_W-1:0] CAP  = GAP_W'(GAP_CAP);

   logic [HANG_W-1:0]     hang_passes_ff, hang_passes_in;
   logic [MISSED_W-1:0]   missed_passes_ff, missed_passes_in;
   logic [GAP_W-1:0]      max_gap_ff, max_gap_in;

   logic [SEQ_W-1:0]      expected_ff, expected_in;
   logic                  busy_ff, busy_in;
   logic [MISSED_W-1:0]   missed_ff, missed_in;
   logic [HANG_W-1:0]     hang_ff, hang_in;

   logic                  plan_header_ff, plan_header_in;
   logic                  plan_frame_ff, plan_frame_in;
   logic                  plan_hang_ff, plan_hang_in;
   logic                  frame_sil_ff, frame_sil_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [SEQ_BYTE_W-1:0] seq_ff, seq_in;
   logic [VOICE_LO_W-1:0] vlow_ff, vlow_in;
   logic [VOICE_HI_W-1:0] vhigh_ff, vhigh_in;
   logic [SLOW_W-1:0]     slow_ff, slow_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EVENT_W-1:0]    event_ff, event_in;
   logic                  sil_ff, sil_in;
   logic [VOICE_LO_W-1:0] ovlow_ff, ovlow_in;
   logic [VOICE_HI_W-1:0] ovhigh_ff, ovhigh_in;
   logic [SLOW_W-1:0]     oslow_ff, oslow_in;
   logic                  last_ff, last_in;

   always_comb begin
      logic [SEQ_W-1:0]    seqm;
      logic [SEQ_W:0]      gap;
      logic [SEQ_W:0]      seq_up;
      logic [GAP_W-1:0]    lim;
      logic [HANG_W-1:0]   hang_work;
      logic [HANG_W-1:0]   hang_new;
      logic [MISSED_W-1:0] missed_inc;
      logic                slow_sil;

      hang_passes_in   = hang_passes_ff;
      missed_passes_in = missed_passes_ff;
      max_gap_in       = max_gap_ff;
      expected_in      = expected_ff;
      busy_in          = busy_ff;
      missed_in        = missed_ff;
      hang_in          = hang_ff;
      plan_header_in   = plan_header_ff;
      plan_frame_in    = plan_frame_ff;
      plan_hang_in     = plan_hang_ff;
      frame_sil_in     = frame_sil_ff;
      cnt_in           = cnt_ff;
      kind_in          = kind_ff;
      seq_in           = seq_ff;
      vlow_in          = vlow_ff;
      vhigh_in         = vhigh_ff;
      slow_in          = slow_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ready;
      event_in         = event_ff;
      sil_in           = sil_ff;
      ovlow_in         = ovlow_ff;
      ovhigh_in        = ovhigh_ff;
      oslow_in         = oslow_ff;
      last_in          = last_ff;

      seqm       = seq_ff[SEQ_W-1:0];
      if ({1'b0, seqm} >= {1'b0, expected_ff}) begin
         gap = {1'b0, seqm} - {1'b0, expected_ff};
      end else begin
         gap = {1'b0, seqm} + PERIOD - {1'b0, expected_ff};
      end
      lim        = (max_gap_ff < CAP) ? max_gap_ff : CAP;
      missed_inc = missed_ff + MISSED_W'(1);
      hang_work  = hang_ff;
      hang_new   = '0;
      seq_up     = {1'b0, expected_ff} + (SEQ_W+1)'(1);
      slow_sil   = 1'b1;

      if (csr_we) begin
         case (csr_index)
            CSR_HANG_PASSES:   hang_passes_in   = csr_wdata[HANG_W-1:0];
            CSR_MISSED_PASSES: missed_passes_in = csr_wdata[MISSED_W-1:0];
            CSR_MAX_GAP:       max_gap_in       = csr_wdata[GAP_W-1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         kind_in  = req_kind;
         seq_in   = req_seq_byte;
         vlow_in  = req_voice_low;
         vhigh_in = req_voice_high;
         slow_in  = req_slow_data;
      end

      if (cmd.decode) begin
         plan_header_in = 1'b0;
         plan_frame_in  = 1'b0;
         frame_sil_in   = 1'b1;
         cnt_in         = '0;
         if (kind_ff == KIND_HEADER) begin
            expected_in    = '0;
            missed_in      = '0;
            busy_in        = 1'b1;
            hang_work      = '0;
            plan_header_in = 1'b1;
            cnt_in         = HDR_FRAMES;
         end else if (kind_ff == KIND_DATA) begin
            missed_in = '0;
            if (seq_ff[END_BIT]) begin
               hang_work = hang_passes_ff;
            end else begin
               hang_work     = '0;
               plan_frame_in = ({1'b0, seqm} < PERIOD) && (gap <= {1'b0, lim});
               cnt_in        = gap[CNT_W-1:0];
               frame_sil_in  = 1'b0;
            end
         end else if (busy_ff) begin
            if (missed_inc == missed_passes_ff) begin
               missed_in     = '0;
               plan_frame_in = 1'b1;
            end else begin
               missed_in = missed_inc;
            end
         end
         hang_new     = hang_work - HANG_W'(1);
         plan_hang_in = 1'b0;
         if (hang_work != '0) begin
            hang_in = hang_new;
            if (hang_new == '0) begin
               plan_hang_in = 1'b1;
               busy_in      = 1'b0;
            end
         end else begin
            hang_in = '0;
         end
      end

      if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         last_in      = cmd.last;
         event_in     = EV_VOICE;
         sil_in       = 1'b0;
         ovlow_in     = '0;
         ovhigh_in    = '0;
         oslow_in     = '0;
         unique case (cmd.op)
            OP_FILL_SLOW, OP_FRAME_SLOW: begin
               slow_sil = (cmd.op == OP_FILL_SLOW) | frame_sil_ff;
               if (expected_ff == '0) begin
                  event_in    = EV_SYNC;
                  expected_in = SEQ_W'(1);
               end else begin
                  event_in = EV_ADD;
                  sil_in   = slow_sil;
                  oslow_in = slow_sil ? '0 : slow_ff;
                  expected_in = (seq_up[SEQ_W-1:0] >= PERIOD[SEQ_W-1:0] && PERIOD <= 
                                 (SEQ_W+1)'(2**SEQ_W - 1)) ? '0 : seq_up[SEQ_W-1:0];
               end
            end
            OP_FILL_VOICE: begin
               sil_in = 1'b1;
            end
            OP_FRAME_VOICE: begin
               sil_in    = frame_sil_ff;
               ovlow_in  = frame_sil_ff ? '0 : vlow_ff;
               ovhigh_in = frame_sil_ff ? '0 : vhigh_ff;
            end
            OP_SLOW_RESET: begin
               event_in = EV_RESET;
            end
            OP_GO_IDLE: begin
               event_in = EV_IDLE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hang_passes_ff   <= HANG_RESET_VAL;
         missed_passes_ff <= MISSED_RESET_VAL;
         max_gap_ff       <= MAX_GAP_RESET;
         expected_ff      <= '0;
         busy_ff          <= 1'b0;
         missed_ff        <= '0;
         hang_ff          <= '0;
         plan_header_ff   <= 1'b0;
         plan_frame_ff    <= 1'b0;
         plan_hang_ff     <= 1'b0;
         frame_sil_ff     <= 1'b0;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         hang_passes_ff   <= hang_passes_in;
         missed_passes_ff <= missed_passes_in;
         max_gap_ff       <= max_gap_in;
         expected_ff      <= expected_in;
         busy_ff          <= busy_in;
         missed_ff        <= missed_in;
         hang_ff          <= hang_in;
         plan_header_ff   <= plan_header_in;
         plan_frame_ff    <= plan_frame_in;
         plan_hang_ff     <= plan_hang_in;
         frame_sil_ff     <= frame_sil_in;
         cnt_ff           <= cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // frame and result payload
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      seq_ff    <= seq_in;
      vlow_ff   <= vlow_in;
      vhigh_ff  <= vhigh_in;
      slow_ff   <= slow_in;
      event_ff  <= event_in;
      sil_ff    <= sil_in;
      ovlow_ff  <= ovlow_in;
      ovhigh_ff <= ovhigh_in;
      oslow_ff  <= oslow_in;
      last_ff   <= last_in;
   end

   assign status.emit_ok     = ~rsp_valid_ff | rsp_ready;
   assign status.plan_header = plan_header_ff;
   assign status.plan_frame  = plan_frame_ff;
   assign status.plan_hang   = plan_hang_ff;
   assign status.cnt_last    = (cnt_ff == CNT_W'(1));
   assign status.cnt_zero    = (cnt_ff == '0);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = event_ff;
   assign rsp_silence        = sil_ff;
   assign rsp_voice_low_res  = ovlow_ff;
   assign rsp_voice_high_res = ovhigh_ff;
   assign rsp_slow_data_res  = oslow_ff;
   assign rsp_last           = last_ff;

endmodule

[src/vfsgf_ctrl.sv]
// controller: sequences the results of one pass
module vfsgf_ctrl import vfsgf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.decode  = 1'b0;
      cmd.emit    = 1'b0;
      cmd.op      = OP_FILL_VOICE;
      cmd.last    = 1'b0;
      cmd.cnt_dec = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.plan_header) begin
               state_in = ST_HDR_VOICE;
            end else if (status.plan_frame) begin
               state_in = status.cnt_zero ? ST_FRAME_SLOW : ST_FILL_SLOW;
            end else if (status.plan_hang) begin
               state_in = ST_HANG_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HDR_VOICE: begin
            cmd.op = OP_FILL_VOICE;
            if (status.emit_ok) begin
               cmd.emit    = 1'b1;
               cmd.cnt_dec = 1'b1;
               if (status.cnt_last) begin
                  state_in = ST_HDR_RESET;
               end
            end
         end
         ST_HDR_RESET: begin
            cmd.op   = OP_SLOW_RESET;
            cmd.last = 1'b1;
            if (status.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FILL_SLOW: begin
            cmd.op = OP_FILL_SLOW;
            if (status.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_FILL_VOICE;
            end
         end
         ST_FILL_VOICE: begin
            cmd.op = OP_FILL_VOICE;
            if (status.emit_ok) begin
               cmd.emit    = 1'b1;
               cmd.cnt_dec = 1'b1;
               state_in    = status.cnt_last ? ST_FRAME_SLOW : ST_FILL_SLOW;
            end
         end
         ST_FRAME_SLOW: begin
            cmd.op = OP_FRAME_SLOW;
            if (status.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_FRAME_VOICE;
            end
         end
         ST_FRAME_VOICE: begin
            cmd.op   = OP_FRAME_VOICE;
            cmd.last = ~status.plan_hang;
            if (status.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = status.plan_hang ? ST_HANG_IDLE : ST_IDLE;
            end
         end
         ST_HANG_IDLE: begin
            cmd.op = OP_GO_IDLE;
            if (status.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_HANG_RESET;
            end
         end
         ST_HANG_RESET: begin
            cmd.op   = OP_SLOW_RESET;
            cmd.last = 1'b1;
            if (status.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
